/* src/divider_and_reload_timer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Divider and reload timer: assertion macros
// Shared property wrappers for the timer's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef DIVIDER_AND_RELOAD_TIMER_UNIT_DEFINES_SVH
`define DIVIDER_AND_RELOAD_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define DRT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer check failed");

// Next-cycle implication, disabled while reset is asserted
`define DRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer check failed");

`endif

/* src/drt_pkg.sv */
// ----------------------------------------------------------------------------
// Divider and reload timer package
// Request codes, register addresses, controller state, command and status.
// ----------------------------------------------------------------------------
package drt_pkg;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    localparam logic [15:0] ADDR_DIVIDER = 16'hFF04;
    localparam logic [15:0] ADDR_COUNTER = 16'hFF05;
    localparam logic [15:0] ADDR_RELOAD  = 16'hFF06;
    localparam logic [15:0] ADDR_CONTROL = 16'hFF07;

    localparam int unsigned LEFT_W  = 11;
    localparam int unsigned WRAPS_W = 5;
    localparam logic [WRAPS_W-1:0] WRAPS_MAX = '1;
    localparam logic [7:0] UNKNOWN_READ = 8'hFF;
    localparam int unsigned ENABLE_BIT = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COUNT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic accept;
        op_t  op;
        logic step;
        logic load_out;
    } drt_cmd_t;

    typedef struct packed {
        logic counting;
        logic step_due;
    } drt_status_t;

    // Counter period in clocks for control bits 1..0
    function automatic logic [LEFT_W-1:0] period_of(input logic [1:0] sel);
        logic [LEFT_W-1:0] p;
        case (sel)
            2'd0:    p = LEFT_W'(1024);
            2'd1:    p = LEFT_W'(16);
            2'd2:    p = LEFT_W'(64);
            default: p = LEFT_W'(256);
        endcase
        return p;
    endfunction

endpackage

/* src/drt_in_if.sv */
// ----------------------------------------------------------------------------
// Timer request channel
// Valid/ready channel carrying one timer request.
// ----------------------------------------------------------------------------
interface drt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] bus_address;
    logic [7:0]  write_byte;
    logic [7:0]  elapsed_cycles;

    modport source (output valid, op, bus_address, write_byte, elapsed_cycles,
                    input ready);
    modport sink (input valid, op, bus_address, write_byte, elapsed_cycles,
                  output ready);
endinterface

/* src/drt_out_if.sv */
// ----------------------------------------------------------------------------
// Timer result channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface drt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [4:0] overflow_count;

    modport source (output valid, read_byte, overflow_count, input ready);
    modport sink (input valid, read_byte, overflow_count, output ready);
endinterface

/* src/drt_datapath.sv */
// ----------------------------------------------------------------------------
// Timer datapath
// Timer registers, divider add, counter stepping and result register.
// ----------------------------------------------------------------------------
module drt_datapath
    import drt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    input  logic [15:0]       bus_address,
    input  logic [7:0]        write_byte,
    input  logic [7:0]        elapsed_cycles,
    input  drt_cmd_t          cmd,
    output drt_status_t       status,
    output logic [7:0]        read_byte,
    output logic [4:0]        overflow_count
);

    logic              paused_reg;
    logic [7:0]        div_reg, div_next;
    logic [7:0]        frac_reg, frac_next;
    logic [7:0]        counter_reg, counter_next;
    logic [7:0]        reload_reg, reload_next;
    logic [2:0]        control_reg, control_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [WRAPS_W-1:0] wraps_reg, wraps_next;
    logic [7:0]        rd_reg, rd_next;
    logic [7:0]        out_rd_reg;
    logic [WRAPS_W-1:0] out_wraps_reg;

    logic [8:0]        frac_sum;
    logic [LEFT_W-1:0] period;
    logic [7:0]        rd_mux;

    assign period   = period_of(control_reg[1:0]);
    assign frac_sum = {1'b0, frac_reg} + {1'b0, elapsed_cycles};

    assign status.counting = control_reg[ENABLE_BIT] && !paused_reg;
    assign status.step_due = (left_reg >= period);

    always_comb
    begin
        case (bus_address)
            ADDR_DIVIDER: rd_mux = div_reg;
            ADDR_COUNTER: rd_mux = counter_reg;
            ADDR_RELOAD:  rd_mux = reload_reg;
            ADDR_CONTROL: rd_mux = {5'b0, control_reg};
            default:      rd_mux = UNKNOWN_READ;
        endcase
    end

    always_comb
    begin
        div_next     = div_reg;
        frac_next    = frac_reg;
        counter_next = counter_reg;
        reload_next  = reload_reg;
        control_next = control_reg;
        left_next    = left_reg;
        wraps_next   = wraps_reg;
        rd_next      = rd_reg;

        if (cmd.accept)
        begin
            wraps_next = '0;
            rd_next    = '0;
            case (cmd.op)
                OP_TICK:
                begin
                    if (!paused_reg)
                    begin
                        div_next  = div_reg + {7'b0, frac_sum[8]};
                        frac_next = frac_sum[7:0];
                        if (control_reg[ENABLE_BIT])
                            left_next = left_reg + {3'b0, elapsed_cycles};
                    end
                end
                OP_READ:
                    rd_next = rd_mux;
                OP_WRITE:
                begin
                    case (bus_address)
                        ADDR_DIVIDER:
                        begin
                            div_next  = '0;
                            frac_next = '0;
                        end
                        ADDR_COUNTER: counter_next = write_byte;
                        ADDR_RELOAD:  reload_next  = write_byte;
                        ADDR_CONTROL: control_next = write_byte[2:0];
                        default:      ;
                    endcase
                end
                default: ;
            endcase
        end
        else if (cmd.step)
        begin
            left_next = left_reg - period;
            if (counter_reg == 8'hFF)
            begin
                counter_next = reload_reg;
                if (wraps_reg != WRAPS_MAX)
                    wraps_next = wraps_reg + 1'b1;
            end
            else
            begin
                counter_next = counter_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            paused_reg  <= 1'b0;
            div_reg     <= '0;
            frac_reg    <= '0;
            counter_reg <= '0;
            reload_reg  <= '0;
            control_reg <= '0;
            left_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
                paused_reg <= cfg_write_data;
            div_reg     <= div_next;
            frac_reg    <= frac_next;
            counter_reg <= counter_next;
            reload_reg  <= reload_next;
            control_reg <= control_next;
            left_reg    <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wraps_reg <= wraps_next;
        rd_reg    <= rd_next;
        if (cmd.load_out)
        begin
            out_rd_reg    <= rd_reg;
            out_wraps_reg <= wraps_reg;
        end
    end

    assign read_byte      = out_rd_reg;
    assign overflow_count = out_wraps_reg;

endmodule

/* src/drt_ctrl.sv */
// ----------------------------------------------------------------------------
// Timer controller
// Sequences request intake, counter stepping and result hand-off.
// ----------------------------------------------------------------------------
`include "divider_and_reload_timer_unit_defines.svh"

module drt_ctrl
    import drt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [1:0]  in_op,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  drt_status_t status,
    output drt_cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd.accept   = in_valid && (state_reg == ST_IDLE);
        cmd.op       = op_t'(in_op);
        cmd.step     = (state_reg == ST_COUNT) && status.step_due;
        cmd.load_out = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    if (cmd.op == OP_TICK && status.counting)
                        state_next = ST_COUNT;
                    else
                        state_next = ST_OUT;
                end
            end
            ST_COUNT:
            begin
                if (!status.step_due)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (cmd.load_out)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Results only leave from the hand-off state, and never overwrite a waiting one
    `DRT_ASSERT_IMPL(a_load_safe, clk, rst_n, cmd.load_out,
        (state_reg == ST_OUT) && (!out_valid_reg || out_ready))
    `DRT_ASSERT_NEXT(a_count_ends, clk, rst_n,
        (state_reg == ST_COUNT) && !status.step_due, state_reg == ST_OUT)
    `DRT_ASSERT_NEXT(a_out_holds, clk, rst_n,
        (state_reg == ST_OUT) && out_valid_reg && !out_ready,
        (state_reg == ST_OUT) && out_valid_reg)
    `DRT_ASSERT_NEXT(a_read_direct, clk, rst_n,
        cmd.accept && (cmd.op == OP_READ || cmd.op == OP_WRITE), state_reg == ST_OUT)

endmodule

/* src/divider_and_reload_timer_unit.sv */
// ----------------------------------------------------------------------------
// Divider and reload timer unit
// Divider, counter, modulo and control registers behind a request channel.
// ----------------------------------------------------------------------------
// One request is handled at a time. A read, a write, an unused request code,
// a paused tick or a tick with the counter disabled is accepted, its result
// registered and then moved to the result register in the hand-off state. A
// tick with the counter enabled steps the counter once per cycle through a
// single subtract-and-compare unit on the leftover cycle count. The leftover
// count stays below 1024 between ticks, so a tick makes at most 79 counter
// increments (period 16 straight after the longest period, leftover 1023 plus
// a tick input of 255). The result register lets the next request be taken while a
// result still waits on the output channel.
module divider_and_reload_timer_unit
    import drt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_write_en,
    input  logic      cfg_write_data,
    drt_in_if.sink    in_ch,
    drt_out_if.source out_ch
);

    drt_cmd_t    cmd;
    drt_status_t status;

    drt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_op     (in_ch.op),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    drt_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .bus_address    (in_ch.bus_address),
        .write_byte     (in_ch.write_byte),
        .elapsed_cycles (in_ch.elapsed_cycles),
        .cmd            (cmd),
        .status         (status),
        .read_byte      (out_ch.read_byte),
        .overflow_count (out_ch.overflow_count)
    );

endmodule

/* tb/tb_divider_and_reload_timer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider and reload timer unit testbench
// Sends every request code with random stalls on both channels,
// keeps a shadow copy of the timer registers to work out each result and
// checks every result field by field, including phases with the clock paused.
// ----------------------------------------------------------------------------
module tb_divider_and_reload_timer_unit;
    import drt_pkg::*;

    localparam int unsigned MAX_GAP         = 19;
    localparam int unsigned RANDOM_REQUESTS = 1250;
    localparam int unsigned RANDOM_PHASES   = 5;
    localparam int unsigned SETTLE_CYCLES   = 200;
    localparam int unsigned IDLE_CYCLES     = 4;
    localparam int unsigned DIVIDER_STEP    = 256;
    localparam int unsigned MAX_PRINTED     = 100;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [4:0] overflow_count;
    } timer_result_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    drt_in_if  req_ch ();
    drt_out_if rsp_ch ();

    divider_and_reload_timer_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_ch          (req_ch),
        .out_ch         (rsp_ch)
    );

    // Shadow copy of the timer
    logic              sh_paused;
    logic [7:0]        sh_divider;
    logic [7:0]        sh_fraction;
    logic [7:0]        sh_counter;
    logic [7:0]        sh_reload;
    logic [2:0]        sh_control;
    logic [LEFT_W-1:0] sh_leftover;

    timer_result_t timer_results_due[$];
    int unsigned   mismatches;
    bit            send_gapless;
    bit            take_gapless;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int draw_wait(input bit gapless);
        return gapless ? 0 : int'($urandom_range(0, MAX_GAP));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (mismatches < MAX_PRINTED)
            $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        mismatches++;
    endtask

    // Applies one request to the shadow registers and returns its result
    function automatic timer_result_t predict_timer_result(input logic [1:0] op,
            input logic [15:0] addr, input logic [7:0] data, input logic [7:0] cycles);
        timer_result_t res;
        int unsigned   total;
        int unsigned   period;
        res = '0;
        case (op)
            OP_TICK:
            begin
                if (!sh_paused)
                begin
                    total       = sh_fraction + cycles;
                    sh_divider  = sh_divider + 8'(total / DIVIDER_STEP);
                    sh_fraction = 8'(total % DIVIDER_STEP);
                    if (sh_control[ENABLE_BIT])
                    begin
                        case (sh_control[1:0])
                            2'd0:    period = 1024;
                            2'd1:    period = 16;
                            2'd2:    period = 64;
                            default: period = 256;
                        endcase
                        // leftover is never cleared, so a period change can
                        // release a long run of increments in one tick
                        sh_leftover = sh_leftover + cycles;
                        while (sh_leftover >= period)
                        begin
                            sh_leftover = sh_leftover - LEFT_W'(period);
                            sh_counter  = sh_counter + 8'd1;
                            if (sh_counter == 8'h00)
                            begin
                                sh_counter = sh_reload;
                                if (res.overflow_count != WRAPS_MAX)
                                    res.overflow_count = res.overflow_count + 5'd1;
                            end
                        end
                    end
                end
            end
            OP_READ:
            begin
                case (addr)
                    ADDR_DIVIDER: res.read_byte = sh_divider;
                    ADDR_COUNTER: res.read_byte = sh_counter;
                    ADDR_RELOAD:  res.read_byte = sh_reload;
                    ADDR_CONTROL: res.read_byte = {5'b0, sh_control};
                    default:      res.read_byte = UNKNOWN_READ;
                endcase
            end
            OP_WRITE:
            begin
                case (addr)
                    ADDR_DIVIDER:
                    begin
                        sh_divider  = '0;
                        sh_fraction = '0;
                    end
                    ADDR_COUNTER: sh_counter = data;
                    ADDR_RELOAD:  sh_reload  = data;
                    ADDR_CONTROL: sh_control = data[2:0];
                    default:      ;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data, input logic [7:0] cycles);
        int gap;
        gap = draw_wait(send_gapless);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.op             <= op;
        req_ch.bus_address    <= addr;
        req_ch.write_byte     <= data;
        req_ch.elapsed_cycles <= cycles;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        timer_results_due.push_back(predict_timer_result(op, addr, data, cycles));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (timer_results_due.size() != 0) @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_clock_paused(input logic paused);
        wait_idle();
        cfg_write_data <= paused;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        sh_paused = paused;
    endtask

    task automatic test_register_access();
        send_request(OP_READ, ADDR_DIVIDER, 8'h00, 8'h00);
        send_request(OP_READ, ADDR_COUNTER, 8'h00, 8'h00);
        send_request(OP_READ, ADDR_RELOAD, 8'h00, 8'h00);
        send_request(OP_READ, ADDR_CONTROL, 8'h00, 8'h00);
        send_request(OP_WRITE, ADDR_COUNTER, 8'hFF, 8'h00);
        send_request(OP_WRITE, ADDR_RELOAD, 8'hFF, 8'hFF);
        // only the low three control bits stick
        send_request(OP_WRITE, ADDR_CONTROL, 8'hFF, 8'h00);
        send_request(OP_READ, ADDR_CONTROL, 8'hFF, 8'hFF);
        send_request(OP_WRITE, ADDR_DIVIDER, 8'hA5, 8'h00);
        send_request(OP_READ, 16'h0000, 8'h00, 8'h00);
        send_request(OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(OP_WRITE, 16'hFF08, 8'h5A, 8'h00);
        send_request(OP_UNUSED, ADDR_COUNTER, 8'hFF, 8'hFF);
    endtask

    task automatic test_counter_wraps();
        // enabled, period 256, counter and modulo at 0xFF
        send_request(OP_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(OP_TICK, 16'h0000, 8'h00, 8'h01);
        send_request(OP_WRITE, ADDR_CONTROL, 8'h04, 8'h00);
        repeat (4) send_request(OP_TICK, 16'h0000, 8'h00, 8'hFF);
        // switch to period 16 with a large leftover: wrap count saturates
        send_request(OP_WRITE, ADDR_CONTROL, 8'h05, 8'h00);
        send_request(OP_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(OP_READ, ADDR_COUNTER, 8'h00, 8'h00);
    endtask

    task automatic test_disabled_and_paused();
        send_request(OP_WRITE, ADDR_CONTROL, 8'h03, 8'h00);
        send_request(OP_TICK, 16'h0000, 8'h00, 8'd200);
        send_request(OP_READ, ADDR_DIVIDER, 8'h00, 8'h00);
        set_clock_paused(1'b1);
        send_request(OP_TICK, 16'h0000, 8'h00, 8'hFF);
        send_request(OP_READ, ADDR_DIVIDER, 8'h00, 8'h00);
        set_clock_paused(1'b0);
    endtask

    task automatic test_random_traffic();
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
        int unsigned pick;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            set_clock_paused(phase == 2 || (phase == RANDOM_PHASES - 1 && $urandom_range(0, 1)));
            for (int n = 0; n < RANDOM_REQUESTS / RANDOM_PHASES; n++)
            begin
                if (n % 40 == 0)
                begin
                    send_gapless = ($urandom_range(0, 3) == 0);
                    take_gapless = ($urandom_range(0, 3) == 0);
                end
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    op = OP_TICK;
                else if (pick < 75)
                    op = OP_READ;
                else if (pick < 95)
                    op = OP_WRITE;
                else
                    op = OP_UNUSED;
                if ($urandom_range(0, 4) == 0)
                    addr = 16'($urandom);
                else
                    addr = ADDR_DIVIDER + 16'($urandom_range(0, 3));
                data = 8'($urandom);
                // keep the counter mostly running and the modulo often high
                if (op == OP_WRITE && addr == ADDR_CONTROL && $urandom_range(0, 3) != 0)
                    data[ENABLE_BIT] = 1'b1;
                if (op == OP_WRITE && addr == ADDR_RELOAD && $urandom_range(0, 1) != 0)
                    data[7:5] = 3'b111;
                send_request(op, addr, data, 8'($urandom));
            end
        end
        send_gapless = 1'b0;
        take_gapless = 1'b0;
    endtask

    initial
    begin : result_checker
        int            gap;
        timer_result_t want;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = draw_wait(take_gapless);
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid) @(posedge clk);
            if (timer_results_due.size() == 0)
                report_mismatch("result with no request outstanding", 0,
                                {rsp_ch.read_byte, rsp_ch.overflow_count});
            else
            begin
                want = timer_results_due.pop_front();
                if (rsp_ch.read_byte !== want.read_byte)
                    report_mismatch("read_byte", want.read_byte, rsp_ch.read_byte);
                if (rsp_ch.overflow_count !== want.overflow_count)
                    report_mismatch("overflow_count", want.overflow_count,
                                    rsp_ch.overflow_count);
            end
        end
    end

    initial
    begin : stimulus
        mismatches   = 0;
        send_gapless = 1'b0;
        take_gapless = 1'b0;
        sh_paused    = 1'b0;
        sh_divider   = '0;
        sh_fraction  = '0;
        sh_counter   = '0;
        sh_reload    = '0;
        sh_control   = '0;
        sh_leftover  = '0;
        rst_n                 <= 1'b0;
        cfg_write_en          <= 1'b0;
        cfg_write_data        <= 1'b0;
        req_ch.valid          <= 1'b0;
        req_ch.op             <= OP_TICK;
        req_ch.bus_address    <= '0;
        req_ch.write_byte     <= '0;
        req_ch.elapsed_cycles <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_register_access();
        test_counter_wraps();
        test_disabled_and_paused();
        test_random_traffic();

        wait_idle();
        // longest request is well under this; late strays show up as mismatches
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS divider_and_reload_timer_unit");
        else
            $display("FAIL divider_and_reload_timer_unit");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("FAIL divider_and_reload_timer_unit");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/drt_pkg.sv
src/drt_in_if.sv
src/drt_out_if.sv
src/drt_datapath.sv
src/drt_ctrl.sv
src/divider_and_reload_timer_unit.sv
tb/tb_divider_and_reload_timer_unit.sv
